// ===== rtl/rtsp_interleaved_deframer_unit_assert.svh =====
// Assertion macros used by the deframer top level.
`ifndef RTSP_INTERLEAVED_DEFRAMER_UNIT_ASSERT_SVH
`define RTSP_INTERLEAVED_DEFRAMER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define RTSP_ID_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define RTSP_ID_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/rtsp_id_pkg.sv =====
// Types, character codes and the line-content step of the RTSP deframer.
`default_nettype none
package rtsp_id_pkg;

  localparam int BODY_LEN_W = 24;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  localparam logic [4:0] KEY_LEN = 5'd14;
  localparam logic [4:0] KEY_BAD = 5'd31;

  localparam logic [3:0] ROLE_RTP_PREFIX  = 4'd0;
  localparam logic [3:0] ROLE_RTP_PAYLOAD = 4'd1;
  localparam logic [3:0] ROLE_METHOD      = 4'd2;
  localparam logic [3:0] ROLE_URL         = 4'd3;
  localparam logic [3:0] ROLE_VERSION     = 4'd4;
  localparam logic [3:0] ROLE_KEY         = 4'd5;
  localparam logic [3:0] ROLE_VALUE       = 4'd6;
  localparam logic [3:0] ROLE_BODY        = 4'd7;
  localparam logic [3:0] ROLE_DELIM       = 4'd8;
  localparam logic [3:0] ROLE_SKIPPED     = 4'd9;

  localparam logic [2:0] VERDICT_NONE    = 3'd0;
  localparam logic [2:0] VERDICT_REQUEST = 3'd1;
  localparam logic [2:0] VERDICT_HEADER  = 3'd2;
  localparam logic [2:0] VERDICT_SKIPPED = 3'd3;
  localparam logic [2:0] VERDICT_BLANK   = 3'd4;

  localparam logic [1:0] SPACE_BAD = 2'd3;

  typedef struct packed {
    logic       at_line_start;
    logic [1:0] space_count;
    logic       segment_nonempty;
    logic       colon_seen;
    logic [4:0] key_idx;
  } line_t;

  localparam line_t LINE_RESET = '{at_line_start: 1'b1, space_count: 2'd0,
                                   segment_nonempty: 1'b0, colon_seen: 1'b0,
                                   key_idx: 5'd0};

  typedef struct packed {
    line_t      line;
    logic [3:0] role;
  } line_step_t;

  typedef struct packed {
    logic clear;
    logic cr_pre;
    logic char_step;
  } digit_ctrl_t;

  typedef struct packed {
    logic [7:0]            byte_value;
    logic [3:0]            byte_role;
    logic [7:0]            rtp_channel;
    logic [15:0]           rtp_length;
    logic [2:0]            line_verdict;
    logic [BODY_LEN_W-1:0] body_length;
    logic                  length_saturated;
    logic                  message_done;
    logic                  frame_done;
  } result_t;

  // Lower-case text of the content-length key.
  function automatic logic [7:0] key_char(logic [4:0] idx);
    logic [7:0] c;
    case (idx)
      5'd0:    c = 8'h63;
      5'd1:    c = 8'h6F;
      5'd2:    c = 8'h6E;
      5'd3:    c = 8'h74;
      5'd4:    c = 8'h65;
      5'd5:    c = 8'h6E;
      5'd6:    c = 8'h74;
      5'd7:    c = 8'h2D;
      5'd8:    c = 8'h6C;
      5'd9:    c = 8'h65;
      5'd10:   c = 8'h6E;
      5'd11:   c = 8'h67;
      5'd12:   c = 8'h74;
      5'd13:   c = 8'h68;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Advance key match and request-line split by one content character.
  function automatic line_step_t content_char(line_t s, logic [7:0] ch, logic req_stage);
    line_step_t r;
    logic [7:0] lc;
    r.line = s;
    lc = (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) ? ch + CASE_OFFSET : ch;
    if (!s.colon_seen) begin
      if (ch == CH_COLON) begin
        r.line.colon_seen = 1'b1;
        r.role = (s.key_idx == 5'd0) ? ROLE_SKIPPED : ROLE_DELIM;
      end else begin
        if (s.key_idx < KEY_LEN && lc == key_char(s.key_idx)) begin
          r.line.key_idx = s.key_idx + 5'd1;
        end else begin
          r.line.key_idx = KEY_BAD;
        end
        r.role = ROLE_KEY;
      end
    end else begin
      r.role = (s.key_idx == 5'd0) ? ROLE_SKIPPED : ROLE_VALUE;
    end
    if (req_stage && s.space_count != SPACE_BAD) begin
      if (ch == CH_SPACE && s.space_count < 2'd2) begin
        if (s.segment_nonempty) begin
          r.line.space_count      = s.space_count + 2'd1;
          r.line.segment_nonempty = 1'b0;
          r.role                  = ROLE_DELIM;
        end else begin
          r.line.space_count = SPACE_BAD;
        end
      end else begin
        r.line.segment_nonempty = 1'b1;
        r.role                  = ROLE_METHOD + {2'b00, s.space_count};
      end
    end
    r.line.at_line_start = 1'b0;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/rtsp_id_digits.sv =====
// Decimal content-length value parser with saturation.
`default_nettype none
module rtsp_id_digits #(
  parameter int LEN_BITS = 24
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire  [7:0]                 ch,
  input  wire rtsp_id_pkg::digit_ctrl_t ctrl,
  output logic [LEN_BITS-1:0]        acc,
  output logic                       overflow
);

  localparam int WIDE_W = LEN_BITS + 4;

  typedef enum logic [1:0] {DG_IDLE, DG_SIGN, DG_DIGITS, DG_DONE} phase_t;

  phase_t              phase;
  phase_t              phase_mid;
  phase_t              phase_next;
  logic [LEN_BITS-1:0] acc_next;
  logic                overflow_next;
  logic                is_digit;
  logic                is_blank;
  logic [WIDE_W-1:0]   acc_wide;
  logic [WIDE_W-1:0]   times_ten;

  assign is_digit = ch >= rtsp_id_pkg::CH_ZERO && ch <= rtsp_id_pkg::CH_NINE;
  assign is_blank = ch == rtsp_id_pkg::CH_SPACE ||
                    (ch >= rtsp_id_pkg::CH_TAB && ch <= rtsp_id_pkg::CH_CR);
  assign acc_wide  = WIDE_W'(acc);
  assign times_ten = (acc_wide << 3) + (acc_wide << 1) + WIDE_W'(ch[3:0]);

  always_comb begin
    // a pending CR ends the value once a sign or digit has begun it, but is skipped before that
    phase_mid = (ctrl.cr_pre && phase != DG_IDLE) ? DG_DONE : phase;
    phase_next    = phase_mid;
    acc_next      = acc;
    overflow_next = overflow;
    if (ctrl.char_step) begin
      case (phase_mid)
        DG_IDLE: begin
          if (!is_blank) begin
            if (ch == rtsp_id_pkg::CH_PLUS) begin
              phase_next = DG_SIGN;
            end else if (is_digit) begin
              acc_next   = LEN_BITS'(ch[3:0]);
              phase_next = DG_DIGITS;
            end else begin
              acc_next   = '0;
              phase_next = DG_DONE;
            end
          end
        end
        DG_SIGN: begin
          if (is_digit) begin
            acc_next   = LEN_BITS'(ch[3:0]);
            phase_next = DG_DIGITS;
          end else begin
            phase_next = DG_DONE;
          end
        end
        DG_DIGITS: begin
          if (is_digit) begin
            if (times_ten[WIDE_W-1:LEN_BITS] != 4'd0) begin
              acc_next      = '1;
              overflow_next = 1'b1;
            end else begin
              acc_next = times_ten[LEN_BITS-1:0];
            end
          end else begin
            phase_next = DG_DONE;
          end
        end
        default: begin
        end
      endcase
    end
    if (ctrl.clear) begin
      phase_next    = DG_IDLE;
      acc_next      = '0;
      overflow_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= DG_IDLE;
      acc      <= '0;
      overflow <= 1'b0;
    end else begin
      phase    <= phase_next;
      acc      <= acc_next;
      overflow <= overflow_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rtsp_id_parser.sv =====
// Per-byte parse state: lines, headers, body count and interleaved frames.
`default_nettype none
module rtsp_id_parser #(
  parameter int LEN_BITS = 24
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     step,
  input  wire  [7:0]              ch,
  output rtsp_id_pkg::result_t    res
);

  localparam int BR_W   = (LEN_BITS > 16) ? LEN_BITS : 16;
  localparam int BODY_W = rtsp_id_pkg::BODY_LEN_W;

  typedef enum logic [2:0] {
    ST_REQ     = 3'd0,
    ST_HDR     = 3'd1,
    ST_BODY    = 3'd2,
    ST_FRM_REQ = 3'd4,
    ST_FRM_HDR = 3'd5
  } stage_t;

  stage_t                   stage, stage_next;
  rtsp_id_pkg::line_t       line, line_next;
  logic                     cr, cr_next;
  logic [1:0]               fidx, fidx_next;
  logic [7:0]               chan, chan_next;
  logic [15:0]              flen, flen_next;
  logic [BR_W-1:0]          br, br_next;
  logic [LEN_BITS-1:0]      clen, clen_next;
  logic                     lflag, lflag_next;

  logic [LEN_BITS-1:0]      acc;
  logic                     overflow;
  rtsp_id_pkg::digit_ctrl_t dctl;
  rtsp_id_pkg::digit_ctrl_t dctl_step;
  rtsp_id_pkg::line_step_t  cr_step;
  rtsp_id_pkg::line_step_t  ch_step;
  logic                     is_req;
  logic                     value_active;
  logic [15:0]              flen_full;
  logic [3:0]               role;
  logic [2:0]               verdict;
  logic                     mdone;
  logic                     fdone;

  assign is_req       = stage == ST_REQ;
  assign value_active = line.colon_seen && line.key_idx == rtsp_id_pkg::KEY_LEN;
  assign flen_full    = {flen[15:8], ch};
  assign cr_step      = rtsp_id_pkg::content_char(line, rtsp_id_pkg::CH_CR, is_req);
  assign ch_step      = rtsp_id_pkg::content_char(cr ? cr_step.line : line, ch, is_req);

  always_comb begin
    stage_next = stage;
    line_next  = line;
    cr_next    = cr;
    fidx_next  = fidx;
    chan_next  = chan;
    flen_next  = flen;
    br_next    = br;
    clen_next  = clen;
    lflag_next = lflag;
    role       = rtsp_id_pkg::ROLE_RTP_PREFIX;
    verdict    = rtsp_id_pkg::VERDICT_NONE;
    mdone      = 1'b0;
    fdone      = 1'b0;
    dctl       = '0;
    case (stage)
      ST_FRM_REQ, ST_FRM_HDR: begin
        case (fidx)
          2'd1: begin
            chan_next = ch;
            fidx_next = 2'd2;
          end
          2'd2: begin
            flen_next = {ch, 8'h00};
            fidx_next = 2'd3;
          end
          2'd3: begin
            flen_next = flen_full;
            if (flen_full == 16'd0) begin
              fdone = 1'b1;
            end else begin
              br_next   = BR_W'(flen_full);
              fidx_next = 2'd0;
            end
          end
          default: begin
            role = rtsp_id_pkg::ROLE_RTP_PAYLOAD;
            if (br <= BR_W'(1)) begin
              br_next = '0;
              fdone   = 1'b1;
            end else begin
              br_next = br - BR_W'(1);
            end
          end
        endcase
        if (fdone) begin
          fidx_next  = 2'd0;
          stage_next = (stage == ST_FRM_REQ) ? ST_REQ : ST_HDR;
        end
      end
      ST_BODY: begin
        role = rtsp_id_pkg::ROLE_BODY;
        if (br <= BR_W'(1)) begin
          mdone = 1'b1;
        end else begin
          br_next = br - BR_W'(1);
        end
      end
      default: begin
        if (ch == rtsp_id_pkg::CH_LF && cr) begin
          role = rtsp_id_pkg::ROLE_DELIM;
          if (line.at_line_start) begin
            verdict = rtsp_id_pkg::VERDICT_BLANK;
            if (clen != '0) begin
              br_next    = BR_W'(clen);
              stage_next = ST_BODY;
              line_next  = rtsp_id_pkg::LINE_RESET;
              cr_next    = 1'b0;
              dctl.clear = 1'b1;
            end else begin
              mdone = 1'b1;
            end
          end else begin
            if (is_req && line.space_count == 2'd2) begin
              verdict = rtsp_id_pkg::VERDICT_REQUEST;
            end else if (line.colon_seen && line.key_idx != 5'd0) begin
              verdict = rtsp_id_pkg::VERDICT_HEADER;
              if (value_active) begin
                clen_next  = acc;
                lflag_next = overflow;
              end
            end else begin
              verdict = rtsp_id_pkg::VERDICT_SKIPPED;
            end
            stage_next = ST_HDR;
            line_next  = rtsp_id_pkg::LINE_RESET;
            cr_next    = 1'b0;
            dctl.clear = 1'b1;
          end
        end else if (ch == rtsp_id_pkg::CH_CR) begin
          // a second CR turns the held one into line content
          if (cr) begin
            line_next   = cr_step.line;
            dctl.cr_pre = value_active;
          end
          cr_next = 1'b1;
          role    = rtsp_id_pkg::ROLE_DELIM;
        end else if (!cr && line.at_line_start && ch == rtsp_id_pkg::CH_DOLLAR) begin
          stage_next = is_req ? ST_FRM_REQ : ST_FRM_HDR;
          fidx_next  = 2'd1;
          role       = rtsp_id_pkg::ROLE_RTP_PREFIX;
        end else begin
          dctl.cr_pre    = cr && value_active;
          dctl.char_step = value_active;
          line_next      = ch_step.line;
          cr_next        = 1'b0;
          role           = ch_step.role;
        end
      end
    endcase
    // message end: drop length, return to the request line
    if (mdone) begin
      clen_next  = '0;
      lflag_next = 1'b0;
      br_next    = '0;
      stage_next = ST_REQ;
      line_next  = rtsp_id_pkg::LINE_RESET;
      cr_next    = 1'b0;
      dctl.clear = 1'b1;
    end
  end

  assign dctl_step = step ? dctl : '0;

  rtsp_id_digits #(
    .LEN_BITS (LEN_BITS)
  ) u_digits (
    .clk      (clk),
    .rst      (rst),
    .ch       (ch),
    .ctrl     (dctl_step),
    .acc      (acc),
    .overflow (overflow)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= ST_REQ;
      line  <= rtsp_id_pkg::LINE_RESET;
      cr    <= 1'b0;
      fidx  <= 2'd0;
      chan  <= 8'd0;
      flen  <= 16'd0;
      br    <= '0;
      clen  <= '0;
      lflag <= 1'b0;
    end else if (step) begin
      stage <= stage_next;
      line  <= line_next;
      cr    <= cr_next;
      fidx  <= fidx_next;
      chan  <= chan_next;
      flen  <= flen_next;
      br    <= br_next;
      clen  <= clen_next;
      lflag <= lflag_next;
    end
  end

  always_comb begin
    res.byte_value       = ch;
    res.byte_role        = role;
    res.rtp_channel      = chan_next;
    res.rtp_length       = flen_next;
    res.line_verdict     = verdict;
    res.body_length      = BODY_W'(clen_next);
    res.length_saturated = lflag_next;
    res.message_done     = mdone;
    res.frame_done       = fdone;
  end

endmodule
`default_nettype wire

// ===== rtl/rtsp_interleaved_deframer_unit.sv =====
// Top level of the RTSP interleaved deframer: byte stream in, tagged bytes out.
// Usage:
//   Feed the control-connection byte stream on s_axis, one byte per request.
//   Each byte comes back on m_axis with its role, the current interleaved
//   frame channel and length, the line verdict on a closing LF, the content
//   length in force, and message/frame completion flags.
//   Path: an accepted byte is registered in the input register, and its tagged
//   result in the result register as the parser steps, raising m_axis_tvalid.
//   Throughput: one byte per cycle while m_axis_tready is high; all parse state
//   updates are one short pass of logic between the input and result registers.
//   Stall: when m_axis_tready is low with a result waiting, the result register
//   holds, the input register takes one more byte if it is empty, then
//   s_axis_tready drops.
//   Reset (rst, synchronous): both registers empty, parser at the start of a
//   request line, frame channel/length and content length zero.
//   m_axis_tlast marks the last byte of an interleaved frame.
`default_nettype none
`include "rtsp_interleaved_deframer_unit_assert.svh"
module rtsp_interleaved_deframer_unit #(
  parameter int LEN_BITS = 24
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [7:0] data_byte
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // [7:0] byte_value, [15:8] rtp_channel, [31:16] rtp_length,
  // [34:32] line_verdict, [58:35] body_length, [59] length_saturated,
  // [60] message_done, [63:61] zero
  output logic [63:0] m_axis_tdata,
  output logic [3:0]  m_axis_tuser,   // [3:0] byte_role
  output logic        m_axis_tlast    // frame_done
);

  // input register
  logic                 in_valid;
  logic [7:0]           in_byte;
  // result register
  logic                 out_valid;
  rtsp_id_pkg::result_t out_res;
  rtsp_id_pkg::result_t res;
  logic                 advance;
  logic                 step;

  // advance the pipe whenever the result slot is free or being drained
  assign advance       = !out_valid || m_axis_tready;
  assign step          = advance && in_valid;
  assign s_axis_tready = !in_valid || advance;

  rtsp_id_parser #(
    .LEN_BITS (LEN_BITS)
  ) u_parser (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .ch   (in_byte),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid <= in_valid;
      end
    end
  end

  // payload: hold unless a new request lands
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
    if (step) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_res.message_done, out_res.length_saturated,
                          out_res.body_length, out_res.line_verdict,
                          out_res.rtp_length, out_res.rtp_channel,
                          out_res.byte_value};
  assign m_axis_tuser  = out_res.byte_role;
  assign m_axis_tlast  = out_res.frame_done;

  `RTSP_ID_ASSERT_NOW(a_done_exclusive, out_valid,
    !(out_res.message_done && out_res.frame_done),
    "message and frame end on one byte")
  `RTSP_ID_ASSERT_NOW(a_verdict_on_delim,
    out_valid && out_res.line_verdict != rtsp_id_pkg::VERDICT_NONE,
    out_res.byte_role == rtsp_id_pkg::ROLE_DELIM,
    "line verdict on a non-delimiter byte")
  `RTSP_ID_ASSERT_NOW(a_frame_end_role, out_valid && out_res.frame_done,
    out_res.byte_role == rtsp_id_pkg::ROLE_RTP_PREFIX ||
    out_res.byte_role == rtsp_id_pkg::ROLE_RTP_PAYLOAD,
    "frame end outside a frame")
  `RTSP_ID_ASSERT_NEXT(a_input_hold, in_valid && !advance,
    in_valid && $stable(in_byte), "stalled input byte lost")

endmodule
`default_nettype wire
